>>> sv/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared widths, operation and status codes, and the per-cell control struct
// for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

   // default number of cells in the list
   localparam int OLE_DEPTH = 64;

   // field widths of the request and response transactions
   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FIND   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd3;

   // what a cell does with its stored value this cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_LEFT,
      CELL_FROM_RIGHT
   } cell_mode_type;

   // control handed to every cell
   typedef struct packed {
      cell_mode_type mode;
      logic          cmp_en;
   } cell_ctrl_type;

endpackage

>>> sv/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded list of signed values kept front to back in a row of cells, with
// push, sorted insert, pop, find and remove-at-position commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. busy then stays high
// through the compare, scan and apply states while the cell row compares
// every entry with the key, the scan stage locates the first flagged cell,
// and the row shifts in one step. rsp_strobe is registered from the apply
// state, rises as busy falls and lasts one cycle; it cannot be held off, so
// capture it when seen. A new command may be issued in the cycle the response
// is shown; no command is taken while one is in progress, whatever DEPTH and
// the list contents.
// ----------------------------------------------------------------------------
module ordered_list_engine import ole_pkg::*; #(
   parameter int DEPTH = OLE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [POS_W-1:0]           req_position,
   output logic                       rsp_strobe,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_result_value,
   output logic [POS_W-1:0]           rsp_found_position,
   output logic [COUNT_W-1:0]         rsp_entry_count
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_SCAN,
      ST_APPLY
   } state_type;

   state_type            state_ff, state_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [VALUE_W-1:0]   key_ff, key_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [CW-1:0]        count_ff, count_in;

   logic                 strobe_ff, strobe_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [VALUE_W-1:0]   rval_ff, rval_in;
   logic [POS_W-1:0]     fpos_ff, fpos_in;
   logic [COUNT_W-1:0]   ecount_ff, ecount_in;

   logic                 accept;
   logic                 do_insert, do_remove, find_hit;

   logic [VALUE_W-1:0]   cell_val [DEPTH];
   logic [DEPTH-1:0]     cell_less, cell_eq;
   cell_ctrl_type        cell_ctrl [DEPTH];

   logic [DEPTH-1:0]     occ, pos_hit, flags;
   logic [DEPTH-1:0]     prefix, first, prev_prefix;
   logic [VALUE_W-1:0]   sel_val;
   logic [IW-1:0]        sel_idx;
   logic [CW+COUNT_W-1:0] count_wide;
   logic [IW+POS_W-1:0]  idx_wide;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // occupancy and position match per cell
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         occ[i]     = (CW'(i) < count_ff);
         pos_hit[i] = (PW'(i) == PW'(pos_ff));
      end
   end

   // flags that mark the target cell for each operation
   always_comb begin
      case (kind_ff)
         KIND_PUSH:   flags = '1;
         KIND_INSERT: flags = ~occ | ~cell_less;
         KIND_POP:    flags = DEPTH'(1);
         KIND_FIND:   flags = occ & cell_eq;
         KIND_REMOVE: flags = pos_hit;
         default:     flags = '0;
      endcase
   end

   ole_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock  (clock),
      .load   (state_ff == ST_SCAN),
      .flags  (flags),
      .prefix (prefix),
      .first  (first)
   );

   assign prev_prefix = prefix << 1;

   // cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_W-1:0] left_val, right_val;

      if (i == 0) begin : g_front
         assign left_val = key_ff;
      end else begin : g_mid_l
         assign left_val = cell_val[i-1];
      end
      if (i == DEPTH - 1) begin : g_back
         assign right_val = cell_val[i];
      end else begin : g_mid_r
         assign right_val = cell_val[i+1];
      end

      // per-cell command
      always_comb begin
         cell_ctrl[i].cmp_en = (state_ff == ST_CMP);
         if (do_insert && first[i]) begin
            cell_ctrl[i].mode = CELL_LOAD;
         end else if (do_insert && prev_prefix[i]) begin
            cell_ctrl[i].mode = CELL_FROM_LEFT;
         end else if (do_remove && prefix[i]) begin
            cell_ctrl[i].mode = CELL_FROM_RIGHT;
         end else begin
            cell_ctrl[i].mode = CELL_HOLD;
         end
      end

      ole_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[i]),
         .key       (key_ff),
         .left_val  (left_val),
         .right_val (right_val),
         .val       (cell_val[i]),
         .less      (cell_less[i]),
         .equal     (cell_eq[i])
      );
   end

   // value and index of the first flagged cell
   always_comb begin
      sel_val = '0;
      sel_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sel_val = sel_val | ({VALUE_W{first[i]}} & cell_val[i]);
         sel_idx = sel_idx | ({IW{first[i]}} & IW'(i));
      end
   end

   // command outcome in the apply cycle
   always_comb begin
      do_insert = 1'b0;
      do_remove = 1'b0;
      find_hit  = 1'b0;
      status_in = STATUS_OK;
      count_in  = count_ff;
      if (state_ff == ST_APPLY) begin
         case (kind_ff)
            KIND_PUSH, KIND_INSERT: begin
               if (count_ff == CW'(DEPTH)) begin
                  status_in = STATUS_FULL;
               end else begin
                  do_insert = 1'b1;
                  count_in  = count_ff + CW'(1);
               end
            end
            KIND_POP: begin
               if (count_ff == '0) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  do_remove = 1'b1;
                  count_in  = count_ff - CW'(1);
               end
            end
            KIND_FIND: begin
               if (prefix[DEPTH-1]) begin
                  find_hit = 1'b1;
               end else begin
                  status_in = STATUS_MISS;
               end
            end
            KIND_REMOVE: begin
               if (PW'(pos_ff) >= PW'(count_ff)) begin
                  status_in = STATUS_MISS;
               end else begin
                  do_remove = 1'b1;
                  count_in  = count_ff - CW'(1);
               end
            end
            default: status_in = STATUS_MISS;
         endcase
      end
   end

   // response fields, narrowed to the port widths
   always_comb begin
      count_wide = {{COUNT_W{1'b0}}, count_in};
      idx_wide   = {{POS_W{1'b0}}, sel_idx};
      strobe_in  = (state_ff == ST_APPLY);
      rval_in    = do_remove ? sel_val : '0;
      fpos_in    = find_hit ? idx_wide[POS_W-1:0] : '0;
      ecount_in  = count_wide[COUNT_W-1:0];
   end

   // sequencer and latched command
   always_comb begin
      kind_in  = accept ? req_kind : kind_ff;
      key_in   = accept ? req_value : key_ff;
      pos_in   = accept ? req_position : pos_ff;
      case (state_ff)
         ST_IDLE:  state_in = accept ? ST_CMP : ST_IDLE;
         ST_CMP:   state_in = ST_SCAN;
         ST_SCAN:  state_in = ST_APPLY;
         ST_APPLY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      key_ff    <= key_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      rval_ff   <= rval_in;
      fpos_ff   <= fpos_in;
      ecount_ff <= ecount_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_result_value   = rval_ff;
   assign rsp_found_position = fpos_ff;
   assign rsp_entry_count    = ecount_ff;

endmodule

>>> sv/ole_cell.sv
// ----------------------------------------------------------------------------
// ole_cell
// One list slot: holds a value, compares it with the broadcast key, and
// takes a new value from the key or from either neighbor.
// ----------------------------------------------------------------------------
module ole_cell import ole_pkg::*; (
   input  logic               clock,
   input  cell_ctrl_type      ctrl,
   input  logic [VALUE_W-1:0] key,
   input  logic [VALUE_W-1:0] left_val,
   input  logic [VALUE_W-1:0] right_val,
   output logic [VALUE_W-1:0] val,
   output logic               less,
   output logic               equal
);

   logic [VALUE_W-1:0] val_ff, val_in;
   logic               less_ff, less_in;
   logic               eq_ff, eq_in;

   // slot update
   always_comb begin
      case (ctrl.mode)
         CELL_HOLD:       val_in = val_ff;
         CELL_LOAD:       val_in = key;
         CELL_FROM_LEFT:  val_in = left_val;
         CELL_FROM_RIGHT: val_in = right_val;
         default:         val_in = val_ff;
      endcase
   end

   // signed compare against the key, captured once per transaction
   always_comb begin
      less_in = ctrl.cmp_en ? ($signed(val_ff) < $signed(key)) : less_ff;
      eq_in   = ctrl.cmp_en ? (val_ff == key) : eq_ff;
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      less_ff <= less_in;
      eq_ff   <= eq_in;
   end

   assign val   = val_ff;
   assign less  = less_ff;
   assign equal = eq_ff;

endmodule

>>> sv/ole_scan.sv
// ----------------------------------------------------------------------------
// ole_scan
// Registered prefix-or across the cell row: marks every cell at or behind
// the first flagged cell, and gives the one-hot of that first cell.
// ----------------------------------------------------------------------------
module ole_scan import ole_pkg::*; #(
   parameter int DEPTH = OLE_DEPTH
) (
   input  logic             clock,
   input  logic             load,
   input  logic [DEPTH-1:0] flags,
   output logic [DEPTH-1:0] prefix,
   output logic [DEPTH-1:0] first
);

   localparam int STEPS = $clog2(DEPTH);

   logic [DEPTH-1:0] prefix_ff, prefix_in;
   logic [DEPTH-1:0] spread;

   // log-step spread of each flag toward the back of the list
   always_comb begin
      spread = flags;
      for (int s = 0; s < STEPS; s++) begin
         spread = spread | (spread << (1 << s));
      end
      prefix_in = load ? spread : prefix_ff;
   end

   always_ff @(posedge clock) begin
      prefix_ff <= prefix_in;
   end

   assign prefix = prefix_ff;
   assign first  = prefix_ff & ~(prefix_ff << 1);

endmodule

>>> sv/ole_checker.sv
// ----------------------------------------------------------------------------
// ole_checker
// Port-level checks of command timing and response consistency for the
// ordered list engine, bound to every instance of the top level.
// ----------------------------------------------------------------------------
module ole_checker import ole_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_strobe,
   input logic [STATUS_W-1:0]        rsp_status,
   input logic [POS_W-1:0]           rsp_found_position,
   input logic [COUNT_W-1:0]         rsp_entry_count
);

   // a response is shown only once the engine is free again
   a_strobe_free: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response shown while busy");

   // an accepted transaction makes the engine busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("engine not busy after accepted transaction");

   // fixed latency from transaction to response
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("response missing four cycles after transaction");

   // an empty pop reports an empty list
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == STATUS_EMPTY)) |-> (rsp_entry_count == '0))
      else $error("empty status with nonzero entry count");

   // a failed transaction carries no position
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK)) |-> (rsp_found_position == '0))
      else $error("position reported on failed transaction");

endmodule

bind ordered_list_engine ole_checker u_ole_checker (.*);

>>> test/tb_ordered_list_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine
// Drives push, sorted insert, pop, find and remove commands into the ordered
// list engine, keeps a queue-based copy of the list to predict every response,
// and checks each strobed response field by field against the oldest
// prediction. A directed opening is followed by random fill and drain phases
// that run the list through empty and full many times.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine import ole_pkg::*; ();

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 930;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;

   // one predicted response transaction
   typedef struct {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] result_value;
      logic [POS_W-1:0]          found_position;
      logic [COUNT_W-1:0]        entry_count;
   } list_reply_type;

   // keeps its own copy of the list and the responses still owed
   class ordered_list_predictor;
      logic signed [VALUE_W-1:0] list_model[$];
      list_reply_type            owed_replies[$];
      int                        errors;

      function new();
         errors = 0;
      endfunction

      function int pending();
         return owed_replies.size();
      endfunction

      // apply one accepted command to the list copy and queue its response
      function void note_command(logic [KIND_W-1:0] kind,
                                 logic signed [VALUE_W-1:0] value,
                                 logic [POS_W-1:0] position);
         list_reply_type r;
         int             k;
         r.status         = STATUS_OK;
         r.result_value   = '0;
         r.found_position = '0;
         k = 0;
         case (kind)
            KIND_PUSH: begin
               if (list_model.size() >= OLE_DEPTH) r.status = STATUS_FULL;
               else list_model.push_front(value);
            end
            KIND_INSERT: begin
               if (list_model.size() >= OLE_DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  // equal values land in front of their equals
                  while (k < list_model.size() && list_model[k] < value) k++;
                  list_model.insert(k, value);
               end
            end
            KIND_POP: begin
               if (list_model.size() == 0) r.status = STATUS_EMPTY;
               else r.result_value = list_model.pop_front();
            end
            KIND_FIND: begin
               while (k < list_model.size() && list_model[k] != value) k++;
               if (k < list_model.size()) r.found_position = POS_W'(k);
               else r.status = STATUS_MISS;
            end
            KIND_REMOVE: begin
               if (position >= list_model.size()) begin
                  r.status = STATUS_MISS;
               end else begin
                  r.result_value = list_model[position];
                  list_model.delete(position);
               end
            end
            default: r.status = STATUS_MISS;
         endcase
         r.entry_count = COUNT_W'(list_model.size());
         owed_replies.push_back(r);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      // compare one strobed response with the oldest prediction
      function void check_response(logic [STATUS_W-1:0] status,
                                   logic signed [VALUE_W-1:0] result_value,
                                   logic [POS_W-1:0] found_position,
                                   logic [COUNT_W-1:0] entry_count);
         list_reply_type r;
         if (owed_replies.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, status %0h value %0h",
                     $time, status, result_value);
         end else begin
            r = owed_replies.pop_front();
            compare_field("status", r.status, status);
            compare_field("result_value", r.result_value, result_value);
            compare_field("found_position", r.found_position, found_position);
            compare_field("entry_count", r.entry_count, entry_count);
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [KIND_W-1:0]         req_kind = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic                      rsp_strobe;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_result_value;
   logic [POS_W-1:0]          rsp_found_position;
   logic [COUNT_W-1:0]        rsp_entry_count;

   ordered_list_predictor list_predictor = new();
   int  cycle_count = 0;
   bit  no_idle = 1'b0;

   ordered_list_engine i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_value          (req_value),
      .req_position       (req_position),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_result_value   (rsp_result_value),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count)
   );

   // clock
   always #CLOCK_HALF clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // monitor: check responses, then note accepted commands
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            list_predictor.check_response(rsp_status, rsp_result_value,
                                          rsp_found_position, rsp_entry_count);
         if (start && !busy)
            list_predictor.note_command(req_kind, req_value, req_position);
      end
   end

   // present one command after a random gap and hold it until taken
   task automatic send_command(logic [KIND_W-1:0] kind,
                               logic signed [VALUE_W-1:0] value,
                               logic [POS_W-1:0] position);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_kind     <= kind;
      req_value    <= value;
      req_position <= position;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // mostly small values so finds hit and inserts tie, plus extremes and wide values
   function automatic logic signed [VALUE_W-1:0] draw_value();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return $signed($urandom_range(0, 16)) - 8;
      else if (pick == 8) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return -32'sd1;
            default: return 32'sd0;
         endcase
      end
      return $urandom;
   endfunction

   // grow phases favor push and insert, drain phases pop and remove
   function automatic logic [KIND_W-1:0] draw_kind(int phase);
      int r;
      r = $urandom_range(0, 99);
      if (r >= 97) return KIND_W'($urandom_range(5, 7));
      case (phase)
         0: begin
            if (r < 40) return KIND_PUSH;
            if (r < 80) return KIND_INSERT;
            if (r < 88) return KIND_FIND;
            if (r < 93) return KIND_POP;
            return KIND_REMOVE;
         end
         1: begin
            if (r < 5) return KIND_PUSH;
            if (r < 10) return KIND_INSERT;
            if (r < 25) return KIND_FIND;
            if (r < 60) return KIND_POP;
            return KIND_REMOVE;
         end
         default: begin
            if (r < 20) return KIND_PUSH;
            if (r < 40) return KIND_INSERT;
            if (r < 60) return KIND_FIND;
            if (r < 78) return KIND_POP;
            return KIND_REMOVE;
         end
      endcase
   endfunction

   // stimulus and end of run
   initial begin
      int phase;
      logic [POS_W-1:0] position;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list cases and unknown kinds
      send_command(KIND_POP, 32'sd0, '0);
      send_command(KIND_REMOVE, 32'sd0, '0);
      send_command(KIND_FIND, 32'sd0, '0);
      send_command(3'd5, 32'sd1, 6'd1);
      send_command(3'd6, 32'sh8000_0000, 6'd32);
      send_command(3'd7, -32'sd1, 6'd63);
      // directed: extremes, signed ordering and ties
      send_command(KIND_PUSH, 32'sh7FFF_FFFF, '0);
      send_command(KIND_PUSH, 32'sh8000_0000, '0);
      send_command(KIND_INSERT, 32'sd0, '0);
      send_command(KIND_INSERT, 32'sd0, 6'd63);
      send_command(KIND_INSERT, -32'sd1, '0);
      send_command(KIND_INSERT, 32'sh7FFF_FFFF, '0);
      send_command(KIND_FIND, 32'sd0, '0);
      send_command(KIND_FIND, 32'sh8000_0000, '0);
      send_command(KIND_FIND, 32'sh7FFF_FFFF, '0);
      send_command(KIND_FIND, 32'sd12345, '0);
      // directed: bad and good positions
      send_command(KIND_REMOVE, 32'sd0, 6'd63);
      send_command(KIND_REMOVE, 32'sd0, 6'd6);
      send_command(KIND_REMOVE, 32'sd0, 6'd5);
      send_command(KIND_REMOVE, 32'sd0, 6'd2);
      send_command(KIND_POP, 32'sd0, '0);
      send_command(KIND_PUSH, 32'sd1, '0);
      send_command(KIND_FIND, 32'sd1, '0);

      // random fill and drain phases, full list and bursts included
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         phase = (i / 90) % 3;
         position = ($urandom_range(0, 9) < 7) ? POS_W'($urandom_range(0, 15))
                                              : POS_W'($urandom_range(0, 63));
         send_command(draw_kind(phase), draw_value(), position);
      end
      start <= 1'b0;

      // wait for outstanding responses, then a short quiet period
      while (list_predictor.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (list_predictor.errors == 0 && list_predictor.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
